[design/rrg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_pkg
// Shared types and constants of the ragged range generator.
// ----------------------------------------------------------------------------
package rrg_pkg;

   localparam int MAX_RUN     = 64;
   localparam int LEN_W       = $clog2(MAX_RUN + 1);
   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_STEP = 2'd1,
      STATUS_TOO_LONG  = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] start;
      logic [DATA_W-1:0] step;
      logic              first_row;
      status_type        status;
      logic [LEN_W-1:0]  len;
   } rrg_entry_type;

endpackage

[design/rrg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_front
// Accepts a row, classifies it and finds its length with a short restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrg_front
   import rrg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [DATA_W-1:0] row_start,
   input  logic signed [DATA_W-1:0] row_limit,
   input  logic signed [DATA_W-1:0] row_step,
   input  logic                     first_row,
   output logic                     entry_valid,
   input  logic                     entry_ready,
   output rrg_entry_type            entry
);

   localparam int CMP_W  = DATA_W + 2 + LEN_W;
   localparam int PROD_W = DATA_W + 1 + LEN_W;
   localparam int CNT_W  = $clog2(LEN_W + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_PUSH
   } state_type;

   state_type           state_ff;
   logic [DATA_W-1:0]   start_ff;
   logic [DATA_W-1:0]   step_ff;
   logic                first_ff;
   logic                zero_ff;
   logic                away_ff;
   logic [DATA_W:0]     dist_ff;
   logic [DATA_W-1:0]   mag_ff;
   logic [CMP_W-1:0]    rem_ff;
   logic [CMP_W-1:0]    div_ff;
   logic [LEN_W-1:0]    quo_ff;
   logic [CNT_W-1:0]    cnt_ff;
   status_type          status_ff;

   logic [DATA_W:0]     dist_in;
   logic [DATA_W-1:0]   mag_in;
   logic                away_in;
   logic                too_long;
   logic [CMP_W-1:0]    num;
   logic                take;

   always_comb begin
      if (row_limit >= row_start) begin
         dist_in = {row_limit[DATA_W-1], row_limit} - {row_start[DATA_W-1], row_start};
      end else begin
         dist_in = {row_start[DATA_W-1], row_start} - {row_limit[DATA_W-1], row_limit};
      end
      mag_in  = row_step[DATA_W-1] ? (DATA_W'(0) - row_step) : row_step;
      away_in = (!row_step[DATA_W-1] && (row_limit < row_start)) ||
                (row_step[DATA_W-1] && (row_limit > row_start));
   end

   assign too_long = PROD_W'(dist_ff) > (PROD_W'(mag_ff) * PROD_W'(MAX_RUN));
   assign num      = CMP_W'(dist_ff) + CMP_W'(mag_ff) - CMP_W'(1);
   assign take     = rem_ff >= div_ff;

   assign in_ready    = (state_ff == S_IDLE);
   assign entry_valid = (state_ff == S_PUSH);

   always_comb begin
      entry.start     = start_ff;
      entry.step      = step_ff;
      entry.first_row = first_ff;
      entry.status    = status_ff;
      entry.len       = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  start_ff <= row_start;
                  step_ff  <= row_step;
                  first_ff <= first_row;
                  zero_ff  <= (row_step == '0);
                  away_ff  <= away_in;
                  dist_ff  <= dist_in;
                  mag_ff   <= mag_in;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               quo_ff <= '0;
               priority if (zero_ff) begin
                  status_ff <= STATUS_ZERO_STEP;
                  state_ff  <= S_PUSH;
               end else if (away_ff) begin
                  status_ff <= STATUS_OK;
                  state_ff  <= S_PUSH;
               end else if (too_long) begin
                  status_ff <= STATUS_TOO_LONG;
                  state_ff  <= S_PUSH;
               end else begin
                  status_ff <= STATUS_OK;
                  rem_ff    <= num;
                  div_ff    <= CMP_W'(mag_ff) << (LEN_W - 1);
                  cnt_ff    <= CNT_W'(LEN_W - 1);
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               if (take) begin
                  rem_ff <= rem_ff - div_ff;
               end
               quo_ff <= (quo_ff << 1) | LEN_W'(take);
               div_ff <= div_ff >> 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (entry_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[design/rrg_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_queue
// Short first-in first-out queue of classified rows between front and back.
// ----------------------------------------------------------------------------
module rrg_queue
   import rrg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  rrg_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output rrg_entry_type pop_entry
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rrg_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_W'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[design/rrg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_back
// Takes classified rows from the queue, keeps the running split offset and
// emits one result word per cycle while its registered output stage is free.
// ----------------------------------------------------------------------------
module rrg_back
   import rrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              entry_valid,
   output logic              entry_ready,
   input  rrg_entry_type     entry,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              value_valid,
   output logic [DATA_W-1:0] seq_value,
   output logic [DATA_W-1:0] row_split,
   output status_type        status,
   output logic              last
);

   logic                busy_ff;
   logic                has_values_ff;
   status_type          cur_status_ff;
   logic [LEN_W-1:0]    remain_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [DATA_W-1:0]   step_ff;
   logic [DATA_W-1:0]   split_ff;
   logic [DATA_W-1:0]   split_in;
   logic                out_valid_ff;
   logic                out_vv_ff;
   logic [DATA_W-1:0]   out_value_ff;
   logic [DATA_W-1:0]   out_split_ff;
   status_type          out_status_ff;
   logic                out_last_ff;
   logic                slot_free;
   logic                emit;
   logic                final_word;

   assign entry_ready = !busy_ff;
   assign slot_free   = !out_valid_ff || out_ready;
   assign emit        = busy_ff && slot_free;
   assign final_word  = !has_values_ff || (remain_ff == LEN_W'(1));
   assign split_in    = (entry.first_row ? '0 : split_ff) + DATA_W'(entry.len);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         split_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!busy_ff && entry_valid) begin
            busy_ff       <= 1'b1;
            split_ff      <= split_in;
            has_values_ff <= (entry.len != '0);
            cur_status_ff <= entry.status;
            remain_ff     <= entry.len;
            value_ff      <= entry.start;
            step_ff       <= entry.step;
         end else if (emit) begin
            value_ff  <= value_ff + step_ff;
            remain_ff <= remain_ff - LEN_W'(1);
            if (final_word) begin
               busy_ff <= 1'b0;
            end
         end
         if (emit) begin
            out_valid_ff  <= 1'b1;
            out_vv_ff     <= has_values_ff;
            out_value_ff  <= has_values_ff ? value_ff : '0;
            out_split_ff  <= final_word ? split_ff : '0;
            out_status_ff <= cur_status_ff;
            out_last_ff   <= final_word;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid   = out_valid_ff;
   assign value_valid = out_vv_ff;
   assign seq_value   = out_value_ff;
   assign row_split   = out_split_ff;
   assign status      = out_status_ff;
   assign last        = out_last_ff;

endmodule

[design/ragged_range_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ragged_range_generator
// Expands rows (start, limit, step) into value sequences with running splits.
// ----------------------------------------------------------------------------
// A row that needs the row-length divide passes the front end in order: it is
// classified as it is taken, its length bound is checked, the divide then finds
// one quotient bit per step (a seven-bit quotient for a run limit of 64) and the
// row is handed off. A zero-step row, a row whose step points away from its limit
// and an overlong row skip the divide. The back end loads a row from the queue
// and then, while its output stage is free, sends one word per cycle, one per
// value or a single word for an empty or failed row, and a two-entry queue lets
// the front end work on the next row meanwhile. The output word is registered;
// while it waits to be taken the back end holds and the front end keeps working
// until the queue is full.
module ragged_range_generator
   import rrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row_start [31:0], row_limit [63:32], row_step [95:64]
   input  logic [95:0] req_tdata,
   // first_row [0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value_valid [0], seq_value [32:1], row_split [64:33], status [66:65], zeros above
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast
);

   rrg_entry_type     front_entry;
   rrg_entry_type     back_entry;
   logic              front_valid;
   logic              front_ready;
   logic              back_valid;
   logic              back_ready;
   logic              value_valid;
   logic [DATA_W-1:0] seq_value;
   logic [DATA_W-1:0] row_split;
   status_type        status;

   rrg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .row_start   (req_tdata[31:0]),
      .row_limit   (req_tdata[63:32]),
      .row_step    (req_tdata[95:64]),
      .first_row   (req_tuser[0]),
      .entry_valid (front_valid),
      .entry_ready (front_ready),
      .entry       (front_entry)
   );

   rrg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_entry (front_entry),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_entry  (back_entry)
   );

   rrg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (back_valid),
      .entry_ready (back_ready),
      .entry       (back_entry),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .value_valid (value_valid),
      .seq_value   (seq_value),
      .row_split   (row_split),
      .status      (status),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, status, row_split, seq_value, value_valid};

endmodule

[design/rrg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_checker
// Port-level checks of the ragged range generator's result stream.
// ----------------------------------------------------------------------------
module rrg_checker
   import rrg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a row was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tlast && (rsp_tdata[32:1] == '0))
      else $error("word without a value is not a lone last word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[66:65] != STATUS_OK) |-> !rsp_tdata[0])
      else $error("error word carries a value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[64:33] == '0))
      else $error("split shown before the last word of a row");

endmodule

bind ragged_range_generator rrg_checker u_rrg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[sim/rrg_expansion_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrg_expansion_check
// Watches both streams of the ragged range generator, expands every accepted
// row into the words it should produce, and compares each result word field
// by field with the oldest expected word. Mismatches are counted and the
// number of words still outstanding is reported to the testbench top.
// ----------------------------------------------------------------------------
module rrg_expansion_check
   import rrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          words_pending
);

   typedef struct {
      logic              value_valid;
      logic [DATA_W-1:0] seq_value;
      logic [DATA_W-1:0] row_split;
      status_type        status;
      logic              last;
   } range_word_type;

   range_word_type    expected_words[$];
   logic [DATA_W-1:0] running_split;

   task automatic push_word(input logic value_valid, input logic [DATA_W-1:0] seq_value,
                            input logic [DATA_W-1:0] row_split, input status_type status,
                            input logic last);
      range_word_type word;
      word.value_valid = value_valid;
      word.seq_value   = seq_value;
      word.row_split   = row_split;
      word.status      = status;
      word.last        = last;
      expected_words.insert(expected_words.size(), word);
   endtask

   task automatic expand_row(input int row_start, input int row_limit, input int row_step,
                             input logic first_row);
      longint            distance;
      longint            magnitude;
      longint            row_len;
      longint            k;
      logic [DATA_W-1:0] value;
      if (first_row)
         running_split = '0;
      if (row_step == 0) begin
         push_word(1'b0, '0, running_split, STATUS_ZERO_STEP, 1'b1);
         return;
      end
      if ((row_step > 0 && row_limit < row_start) || (row_step < 0 && row_limit > row_start)) begin
         row_len = 0;
      end else begin
         distance  = longint'(row_limit) - longint'(row_start);
         magnitude = longint'(row_step);
         if (distance < 0)
            distance = -distance;
         if (magnitude < 0)
            magnitude = -magnitude;
         row_len = (distance + magnitude - 1) / magnitude;
      end
      if (row_len > MAX_RUN) begin
         push_word(1'b0, '0, running_split, STATUS_TOO_LONG, 1'b1);
      end else if (row_len == 0) begin
         push_word(1'b0, '0, running_split, STATUS_OK, 1'b1);
      end else begin
         running_split = running_split + DATA_W'(row_len);
         value = row_start;
         for (k = 0; k < row_len; k++) begin
            if (k == row_len - 1)
               push_word(1'b1, value, running_split, STATUS_OK, 1'b1);
            else
               push_word(1'b1, value, '0, STATUS_OK, 1'b0);
            value = value + row_step;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] expected,
                                input logic [DATA_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0h, actual %0h", name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      range_word_type want;
      if (reset) begin
         running_split = '0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no expected word: %0h last %0b", rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               compare_field("value_valid", DATA_W'(want.value_valid), DATA_W'(rsp_tdata[0]));
               compare_field("seq_value", want.seq_value, rsp_tdata[32:1]);
               compare_field("row_split", want.row_split, rsp_tdata[64:33]);
               compare_field("status", DATA_W'(want.status), DATA_W'(rsp_tdata[66:65]));
               compare_field("padding", '0, DATA_W'(rsp_tdata[71:67]));
               compare_field("last", DATA_W'(want.last), DATA_W'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            expand_row(int'(req_tdata[31:0]), int'(req_tdata[63:32]), int'(req_tdata[95:64]),
                       req_tuser[0]);
      end
      words_pending <= expected_words.size();
   end

endmodule

[sim/tb_ragged_range_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ragged_range_generator
// Drives rows into the ragged range generator: a directed set covering the
// extremes and every special row, then random rows in four phases of sender
// idling and receiver stalling. A separate checker predicts and compares the
// result words; this module supplies stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_ragged_range_generator;
   import rrg_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int ROWS_PER_PHASE = 52;
   localparam int MOST_NEG       = 32'h8000_0000;
   localparam int MOST_POS       = 32'h7fff_ffff;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // row_start [31:0], row_limit [63:32], row_step [95:64]
   logic [95:0] req_tdata  = '0;
   // first_row [0]
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // value_valid [0], seq_value [32:1], row_split [64:33], status [66:65], zeros above
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;
   int mismatch_count;
   int words_pending;

   ragged_range_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   rrg_expansion_check row_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_row(input int row_start, input int row_limit, input int row_step,
                           input logic first_row);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row_step, row_limit, row_start};
      req_tuser  <= first_row;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
   endtask

   // Most rows are well formed with a chosen length; the rest are zero steps,
   // empty rows, overlong rows and raw noise.
   task automatic send_random_row();
      int     row_start;
      int     row_limit;
      int     row_step;
      int     pick;
      int     run_len;
      int     tries;
      longint magnitude;
      longint span;
      longint far_end;
      logic   first_row;
      bit     downward;
      first_row = ($urandom_range(99) < 15);
      pick      = $urandom_range(99);
      row_start = $urandom;
      row_limit = $urandom;
      row_step  = $urandom;
      if (pick < 10) begin
         first_row = $urandom_range(1);
      end else if (pick < 18) begin
         row_step = 0;
      end else if (pick < 26) begin
         if (row_step == 0)
            row_step = 1;
         if ((row_step > 0) == (row_limit > row_start))
            {row_start, row_limit} = {row_limit, row_start};
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: magnitude = $urandom_range(6, 1);
            6, 7:             magnitude = $urandom_range(1000, 7);
            default:          magnitude = $urandom_range(MOST_POS, 1001);
         endcase
         if (pick < 34)
            run_len = $urandom_range(90, MAX_RUN + 1);
         else if ($urandom_range(9) < 8)
            run_len = $urandom_range(10, 1);
         else
            run_len = $urandom_range(MAX_RUN, 11);
         downward = $urandom_range(1);
         span     = magnitude * (run_len - 1) + longint'($urandom_range(magnitude, 1));
         far_end  = 0;
         for (tries = 0; tries < 8; tries++) begin
            row_start = $urandom;
            far_end   = downward ? longint'(row_start) - span : longint'(row_start) + span;
            if (far_end >= MOST_NEG && far_end <= MOST_POS)
               break;
         end
         row_limit = int'(far_end);
         row_step  = downward ? -int'(magnitude) : int'(magnitude);
      end
      send_row(row_start, row_limit, row_step, first_row);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      int idle_pcts[4]  = '{0, 73, 0, 37};
      int stall_pcts[4] = '{0, 0, 73, 37};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_row(0, 5, 1, 1'b1);
      send_row(10, 0, -3, 1'b0);
      send_row(5, 10, 0, 1'b0);
      send_row(0, 0, 0, 1'b1);
      send_row(7, 7, 1, 1'b0);
      send_row(0, 10, -1, 1'b0);
      send_row(0, 65, 1, 1'b0);
      send_row(0, 64, 1, 1'b0);
      send_row(0, -64, -1, 1'b0);
      send_row(MOST_NEG, MOST_POS, 1, 1'b1);
      send_row(MOST_NEG, MOST_POS, MOST_POS, 1'b0);
      send_row(MOST_POS, MOST_NEG, MOST_NEG, 1'b0);
      send_row(MOST_POS, MOST_NEG, -1, 1'b0);
      send_row(MOST_NEG, MOST_POS, MOST_NEG, 1'b0);
      send_row(-1, 0, MOST_POS, 1'b0);
      send_row(-1, -1, -1, 1'b1);
      send_row(MOST_POS - 2, MOST_POS, 2, 1'b0);
      send_row(MOST_NEG + 3, MOST_NEG, -1, 1'b0);
      send_row(100, 1, -33, 1'b0);
      send_row(-5, 5, 3, 1'b1);
      wait_for_results();

      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_pcts[phase];
         receiver_stall_pct = stall_pcts[phase];
         for (n = 0; n < ROWS_PER_PHASE; n++)
            send_random_row();
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
design/rrg_pkg.sv
design/rrg_front.sv
design/rrg_queue.sv
design/rrg_back.sv
design/ragged_range_generator.sv
design/rrg_checker.sv
sim/rrg_expansion_check.sv
sim/tb_ragged_range_generator.sv
